[hw/rtl/u8c_pkg.sv]
// shared types, constants and helpers of the utf-8 code point codec
`default_nettype none

package u8c_pkg;

   // beat widths on the stream ports
   localparam int ReqDataW = 80;
   localparam int RspDataW = 88;

   // encode length thresholds
   localparam logic [31:0] CpTooBig = 32'h8000_0000;
   localparam logic [31:0] CpLen6   = 32'h0400_0000;
   localparam logic [31:0] CpLen5   = 32'h0020_0000;
   localparam logic [31:0] CpLen4   = 32'h0001_0000;
   localparam logic [31:0] CpLen3   = 32'h0000_0800;
   localparam logic [31:0] CpLen2   = 32'h0000_0080;

   // replacement character for an oversized code point
   localparam logic [7:0] QuestionMark = 8'h3F;

   // operation selector
   typedef enum logic {
      FUNC_DECODE = 1'b0,
      FUNC_ENCODE = 1'b1
   } func_type;

   // result status
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CONT    = 2'd1,
      ST_BADLEAD = 2'd2,
      ST_TOOBIG  = 2'd3
   } status_type;

   // classified item, between the classify and assemble stages
   typedef struct packed {
      func_type   func;
      logic [47:0] utf8_bytes;
      logic [31:0] code_point;
      logic [2:0]  byte_count;
      status_type  status;
   } class_type;

   // finished result
   typedef struct packed {
      logic [30:0] decoded_point;
      logic [47:0] encoded_bytes;
      logic [2:0]  byte_count;
      status_type  status;
   } result_type;

   // continuation byte carrying six payload bits
   function automatic logic [7:0] cont_byte(input logic [5:0] bits);
      cont_byte = {2'b10, bits};
   endfunction

endpackage : u8c_pkg

`default_nettype wire

[hw/rtl/u8c_classify.sv]
// first stage: lead byte length and encode length selection
`default_nettype none

module u8c_classify (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire u8c_pkg::func_type   in_func,
   input  wire logic [47:0]         in_utf8_bytes,
   input  wire logic [31:0]         in_code_point,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output u8c_pkg::class_type       out_item
);
   import u8c_pkg::*;

   logic       valid_ff;
   class_type  item_ff;
   class_type  item_in;
   logic [7:0] lead;

   assign lead = in_utf8_bytes[7:0];

   // length and status from the lead byte or the code point magnitude
   always_comb begin
      item_in.func       = in_func;
      item_in.utf8_bytes = in_utf8_bytes;
      item_in.code_point = in_code_point;
      item_in.byte_count = 3'd1;
      item_in.status     = ST_OK;
      if (in_func == FUNC_DECODE) begin
         unique casez (lead)
            8'b0???????: item_in.byte_count = 3'd1;
            8'b10??????: item_in.status     = ST_CONT;
            8'b110?????: item_in.byte_count = 3'd2;
            8'b1110????: item_in.byte_count = 3'd3;
            8'b11110???: item_in.byte_count = 3'd4;
            8'b111110??: item_in.byte_count = 3'd5;
            8'b1111110?: item_in.byte_count = 3'd6;
            default:     item_in.status     = ST_BADLEAD;
         endcase
      end else begin
         if ((in_code_point & CpTooBig) != 32'd0) begin
            item_in.status = ST_TOOBIG;
         end else if (in_code_point < CpLen2) begin
            item_in.byte_count = 3'd1;
         end else if (in_code_point < CpLen3) begin
            item_in.byte_count = 3'd2;
         end else if (in_code_point < CpLen4) begin
            item_in.byte_count = 3'd3;
         end else if (in_code_point < CpLen5) begin
            item_in.byte_count = 3'd4;
         end else if (in_code_point < CpLen6) begin
            item_in.byte_count = 3'd5;
         end else begin
            item_in.byte_count = 3'd6;
         end
      end
   end

   // stage register, moves when empty or when downstream takes the beat
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule : u8c_classify

`default_nettype wire

[hw/rtl/u8c_assemble.sv]
// second stage: gathers the decoded point or lays out the encoded bytes
`default_nettype none

module u8c_assemble (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire u8c_pkg::class_type  in_item,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output u8c_pkg::result_type      out_item
);
   import u8c_pkg::*;

   logic        valid_ff;
   result_type  item_ff;
   result_type  item_in;
   logic [7:0]  b0, b1, b2, b3, b4, b5;
   logic [31:0] cp;

   assign b0 = in_item.utf8_bytes[7:0];
   assign b1 = in_item.utf8_bytes[15:8];
   assign b2 = in_item.utf8_bytes[23:16];
   assign b3 = in_item.utf8_bytes[31:24];
   assign b4 = in_item.utf8_bytes[39:32];
   assign b5 = in_item.utf8_bytes[47:40];
   assign cp = in_item.code_point;

   // payload gathering and byte layout per length
   always_comb begin
      item_in.decoded_point = 31'd0;
      item_in.encoded_bytes = 48'd0;
      item_in.byte_count    = in_item.byte_count;
      item_in.status        = in_item.status;
      if (in_item.func == FUNC_DECODE) begin
         if (in_item.status == ST_OK) begin
            case (in_item.byte_count)
               3'd2: item_in.decoded_point = {20'd0, b0[4:0], b1[5:0]};
               3'd3: item_in.decoded_point = {15'd0, b0[3:0], b1[5:0], b2[5:0]};
               3'd4: item_in.decoded_point = {10'd0, b0[2:0], b1[5:0], b2[5:0],
                                              b3[5:0]};
               3'd5: item_in.decoded_point = {5'd0, b0[1:0], b1[5:0], b2[5:0],
                                              b3[5:0], b4[5:0]};
               3'd6: item_in.decoded_point = {b0[0], b1[5:0], b2[5:0], b3[5:0],
                                              b4[5:0], b5[5:0]};
               default: item_in.decoded_point = {24'd0, b0[6:0]};
            endcase
         end
      end else begin
         if (in_item.status == ST_TOOBIG) begin
            item_in.encoded_bytes = {40'd0, QuestionMark};
         end else begin
            case (in_item.byte_count)
               3'd2: item_in.encoded_bytes = {32'd0, cont_byte(cp[5:0]),
                                              3'b110, cp[10:6]};
               3'd3: item_in.encoded_bytes = {24'd0, cont_byte(cp[5:0]),
                                              cont_byte(cp[11:6]), 4'b1110,
                                              cp[15:12]};
               3'd4: item_in.encoded_bytes = {16'd0, cont_byte(cp[5:0]),
                                              cont_byte(cp[11:6]),
                                              cont_byte(cp[17:12]), 5'b11110,
                                              cp[20:18]};
               3'd5: item_in.encoded_bytes = {8'd0, cont_byte(cp[5:0]),
                                              cont_byte(cp[11:6]),
                                              cont_byte(cp[17:12]),
                                              cont_byte(cp[23:18]), 6'b111110,
                                              cp[25:24]};
               3'd6: item_in.encoded_bytes = {cont_byte(cp[5:0]),
                                              cont_byte(cp[11:6]),
                                              cont_byte(cp[17:12]),
                                              cont_byte(cp[23:18]),
                                              cont_byte(cp[29:24]), 7'b1111110,
                                              cp[30]};
               default: item_in.encoded_bytes = {41'd0, cp[6:0]};
            endcase
         end
      end
   end

   // stage register
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule : u8c_assemble

`default_nettype wire

[hw/rtl/utf8_codepoint_codec_core.sv]
// top level of the utf-8 code point codec: classify, assemble, output register
//
//   channel | direction | tdata fields (lowest bit up)                | tuser
//   req_    | in        | utf8_bytes[47:0], code_point[79:48]          | func
//   rsp_    | out       | decoded_point[30:0], encoded_bytes[78:31],   | -
//           |           | byte_count[81:79], status[83:82], pad zero   |
//
// one beat a cycle sustained while rsp_tready stays high; rsp_tvalid rises once the
// accepted beat has passed the classify, assemble and output registers
// reset clears the stage valid bits only; payload registers are not reset
// a stall at rsp_tready backs up stage by stage; empty stages still fill
`default_nettype none

module utf8_codepoint_codec_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // utf8_bytes[47:0], code_point[79:48]
   input  wire logic [u8c_pkg::ReqDataW-1:0] req_tdata,
   // func
   input  wire logic                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // decoded_point[30:0], encoded_bytes[78:31], byte_count[81:79],
   // status[83:82], zeros above
   output logic [u8c_pkg::RspDataW-1:0]      rsp_tdata
);
   import u8c_pkg::*;

   logic       cls_valid, cls_ready;
   class_type  cls_item;
   logic       asm_valid, asm_ready;
   result_type asm_item;
   logic       out_valid_ff;
   result_type out_item_ff;
   func_type   req_func;

   assign req_func = func_type'(req_tuser);

   // classify stage
   u8c_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_func       (req_func),
      .in_utf8_bytes (req_tdata[47:0]),
      .in_code_point (req_tdata[79:48]),
      .out_valid     (cls_valid),
      .out_ready     (cls_ready),
      .out_item      (cls_item)
   );

   // assemble stage
   u8c_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_item   (cls_item),
      .out_valid (asm_valid),
      .out_ready (asm_ready),
      .out_item  (asm_item)
   );

   // output register
   assign asm_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (asm_ready) begin
         out_valid_ff <= asm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (asm_ready && asm_valid) begin
         out_item_ff <= asm_item;
      end
   end

   // beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_item_ff.status, out_item_ff.byte_count,
                        out_item_ff.encoded_bytes, out_item_ff.decoded_point};

endmodule : utf8_codepoint_codec_core

`default_nettype wire
